@@ design/sshd_pkg.sv @@
// Shared constants and types for the serial sync header deframer.
package sshd_pkg;

  // Header geometry
  localparam int unsigned HDR_W = 50;
  localparam logic [5:0] HDR_BITS = 6'd50;
  localparam int unsigned LEN_LSB = 30;
  localparam int unsigned LEN_W = 8;

  // Payload word geometry
  localparam int unsigned WORD_W = 10;
  localparam logic [3:0] WORD_LAST_BIT = 4'd9;

  // Result kinds
  typedef enum logic {
    EVT_SYNC = 1'b0,
    EVT_WORD = 1'b1
  } event_kind_t;

endpackage

@@ design/serial_sync_header_deframer.sv @@
// Serial sync header deframer: lock on a sync word, then split packets into payload words.
//
// Usage:
// - Input channel (in_valid / in_stall / serial_bit) carries one link bit per transfer,
//   most significant bit first.
// - Until locked, each bit shifts into a 50-bit hunt register, which is compared with
//   sync_pattern. A match sets the lock (never lost) and yields a sync result.
// - After the lock, 50-bit headers are collected; header bits 37..30 give the payload
//   length in 10-bit words. A zero length goes straight on to the next header.
// - Each completed payload word yields a result with the raw header, the word index
//   and a last flag.
// - sync_pattern is written with sync_pattern_wr high; write it only while idle.
// Timing:
// - One bit is taken every cycle while in_stall is low; the result of a bit appears on
//   the output register in the cycle after its transfer.
// - A stalled result is held in the output register; in_stall rises only while that
//   register is full and stalled, so no bit is taken that could not be reported.
// Reset (rst, synchronous): clears lock, counters and the output valid;
// the sync register returns to zero.
module serial_sync_header_deframer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        sync_pattern_wr,
  input  logic [49:0] sync_pattern,
  // bit input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        serial_bit,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        event_kind,
  output logic [49:0] packet_header,
  output logic [9:0]  payload_word,
  output logic [7:0]  word_index,
  output logic        last_word
);

  // Configuration and state
  logic [49:0] sync_reg;
  logic        locked;
  logic [49:0] header_shift;
  logic [5:0]  header_bits_left;
  logic [7:0]  payload_words;
  logic [9:0]  word_shift;
  logic [3:0]  bits_in_word;
  logic [7:0]  words_done;

  logic        locked_next;
  logic [49:0] header_shift_next;
  logic [5:0]  header_bits_left_next;
  logic [7:0]  payload_words_next;
  logic [9:0]  word_shift_next;
  logic [3:0]  bits_in_word_next;
  logic [7:0]  words_done_next;

  // Result candidate
  logic                 emit;
  sshd_pkg::event_kind_t emit_kind;
  logic [49:0]          emit_header;
  logic [9:0]           emit_word;
  logic [7:0]           emit_index;
  logic                 emit_last;

  logic        take;
  logic [49:0] hdr_shifted;
  logic [9:0]  word_shifted;
  logic [7:0]  done_inc;
  logic [7:0]  hdr_len;

  // Take a bit whenever the output register is free or draining
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  assign hdr_shifted  = {header_shift[48:0], serial_bit};
  assign word_shifted = {word_shift[8:0], serial_bit};
  assign done_inc     = words_done + 8'd1;
  assign hdr_len      = hdr_shifted[sshd_pkg::LEN_LSB +: sshd_pkg::LEN_W];

  // Advance the framing state for one bit
  always_comb begin
    locked_next           = locked;
    header_shift_next     = header_shift;
    header_bits_left_next = header_bits_left;
    payload_words_next    = payload_words;
    word_shift_next       = word_shift;
    bits_in_word_next     = bits_in_word;
    words_done_next       = words_done;
    emit        = 1'b0;
    emit_kind   = sshd_pkg::EVT_SYNC;
    emit_header = hdr_shifted;
    emit_word   = '0;
    emit_index  = '0;
    emit_last   = 1'b0;
    if (!locked) begin
      header_shift_next = hdr_shifted;
      if (hdr_shifted == sync_reg) begin
        locked_next           = 1'b1;
        header_bits_left_next = sshd_pkg::HDR_BITS;
        emit                  = 1'b1;
      end
    end else if (header_bits_left != 6'd0) begin
      header_shift_next     = hdr_shifted;
      header_bits_left_next = header_bits_left - 6'd1;
      if (header_bits_left == 6'd1) begin
        payload_words_next = hdr_len;
        if (hdr_len == 8'd0) begin
          header_bits_left_next = sshd_pkg::HDR_BITS;
        end else begin
          word_shift_next   = '0;
          bits_in_word_next = '0;
          words_done_next   = '0;
        end
      end
    end else begin
      word_shift_next   = word_shifted;
      bits_in_word_next = bits_in_word + 4'd1;
      if (bits_in_word >= sshd_pkg::WORD_LAST_BIT) begin
        emit              = 1'b1;
        emit_kind         = sshd_pkg::EVT_WORD;
        emit_header       = header_shift;
        emit_word         = word_shifted;
        emit_index        = words_done;
        emit_last         = (done_inc == payload_words);
        words_done_next   = done_inc;
        bits_in_word_next = '0;
        word_shift_next   = '0;
        if (done_inc == payload_words) begin
          header_bits_left_next = sshd_pkg::HDR_BITS;
        end
      end
    end
  end

  // Hold the sync word register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg <= '0;
    end else if (sync_pattern_wr) begin
      sync_reg <= sync_pattern;
    end
  end

  // Update framing state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      locked           <= 1'b0;
      header_shift     <= '0;
      header_bits_left <= '0;
      payload_words    <= '0;
      word_shift       <= '0;
      bits_in_word     <= '0;
      words_done       <= '0;
    end else if (take) begin
      locked           <= locked_next;
      header_shift     <= header_shift_next;
      header_bits_left <= header_bits_left_next;
      payload_words    <= payload_words_next;
      word_shift       <= word_shift_next;
      bits_in_word     <= bits_in_word_next;
      words_done       <= words_done_next;
    end
  end

  // Output register valid: load on a result, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= take && emit;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      event_kind    <= emit_kind;
      packet_header <= emit_header;
      payload_word  <= emit_word;
      word_index    <= emit_index;
      last_word     <= emit_last;
    end
  end

`ifndef SYNTHESIS
  // Lock is never lost
  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    locked |=> locked)
    else $error("lock dropped");

  // A sync result is only produced while the lock is being acquired
  a_sync_sets_lock: assert property (@(posedge clk) disable iff (rst)
    (take && emit && emit_kind == sshd_pkg::EVT_SYNC) |-> !locked ##1 locked)
    else $error("sync result without lock transition");

  // Bit count within a word stays below the word width
  a_word_bits_range: assert property (@(posedge clk) disable iff (rst)
    bits_in_word <= sshd_pkg::WORD_LAST_BIT)
    else $error("word bit counter out of range");

  // Header bit count never exceeds one header
  a_header_bits_range: assert property (@(posedge clk) disable iff (rst)
    header_bits_left <= sshd_pkg::HDR_BITS)
    else $error("header bit counter out of range");

  // Payload words are only collected after lock
  a_words_after_lock: assert property (@(posedge clk) disable iff (rst)
    (take && emit && emit_kind == sshd_pkg::EVT_WORD) |-> locked)
    else $error("payload word before lock");
`endif

endmodule

@@ dv/tb_serial_sync_header_deframer.sv @@
// Self-checking testbench for the serial sync header deframer.
module tb_serial_sync_header_deframer;

  typedef struct packed {
    sshd_pkg::event_kind_t kind;
    logic [49:0] header;
    logic [9:0]  word;
    logic [7:0]  index;
    logic        last;
  } deframe_result_t;

  typedef enum logic {
    ROW_CFG_WRITE = 1'b0,
    ROW_BITS      = 1'b1
  } row_op_t;

  // One directed row: a register write, or a run of bits sent MSB first
  typedef struct packed {
    row_op_t         op;
    logic [5:0]      nbits;
    logic [49:0]     value;
    logic            typed;
    deframe_result_t res;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 15;
  localparam logic [49:0] ALL_ONES = 50'h3FFFFFFFFFFFF;
  localparam logic [49:0] EARLY_SYNC = 50'h2A5;
  localparam int unsigned OUT_LATENCY = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sync_pattern_wr = 1'b0;
  logic [49:0] sync_pattern = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        serial_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        event_kind;
  logic [49:0] packet_header;
  logic [9:0]  payload_word;
  logic [7:0]  word_index;
  logic        last_word;

  // Deframer prediction state
  logic [49:0] sync_word;
  logic        link_locked;
  logic [49:0] hdr_shift;
  logic [5:0]  hdr_left;
  logic [7:0]  pay_len;
  logic [9:0]  word_acc;
  logic [3:0]  word_fill;
  logic [7:0]  word_count;

  deframe_result_t pending_results[$];
  stim_row_t       directed_rows [DIRECTED_ROWS];
  int unsigned     mismatch_count = 0;
  int unsigned     bits_sent = 0;
  bit              steady = 1'b0;
  bit              pressure_go = 1'b0;

  serial_sync_header_deframer i_dut (
    .clk             (clk),
    .rst             (rst),
    .sync_pattern_wr (sync_pattern_wr),
    .sync_pattern    (sync_pattern),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .serial_bit      (serial_bit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_kind      (event_kind),
    .packet_header   (packet_header),
    .payload_word    (payload_word),
    .word_index      (word_index),
    .last_word       (last_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the predicted deframer by one link bit
  task automatic advance_deframer(input logic b, output logic got, output deframe_result_t r);
    logic [7:0] next_count;
    got = 1'b0;
    r = '0;
    if (!link_locked) begin
      hdr_shift = {hdr_shift[48:0], b};
      if (hdr_shift == sync_word) begin
        link_locked = 1'b1;
        hdr_left = sshd_pkg::HDR_BITS;
        r = '{sshd_pkg::EVT_SYNC, hdr_shift, 10'h0, 8'h0, 1'b0};
        got = 1'b1;
      end
    end else if (hdr_left != 0) begin
      hdr_shift = {hdr_shift[48:0], b};
      hdr_left = hdr_left - 6'd1;
      if (hdr_left == 0) begin
        pay_len = hdr_shift[sshd_pkg::LEN_LSB +: sshd_pkg::LEN_W];
        // Skip straight to the next header on a zero length
        if (pay_len == 0) begin
          hdr_left = sshd_pkg::HDR_BITS;
        end else begin
          word_acc = '0;
          word_fill = '0;
          word_count = '0;
        end
      end
    end else begin
      word_acc = {word_acc[8:0], b};
      word_fill = word_fill + 4'd1;
      if (word_fill > sshd_pkg::WORD_LAST_BIT) begin
        next_count = word_count + 8'd1;
        r = '{sshd_pkg::EVT_WORD, hdr_shift, word_acc, word_count, next_count == pay_len};
        got = 1'b1;
        word_count = next_count;
        word_fill = '0;
        word_acc = '0;
        if (r.last) hdr_left = sshd_pkg::HDR_BITS;
      end
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one bit, wait for its transfer, then record what it should produce
  task automatic send_bit(input logic b, input logic use_typed, input deframe_result_t typed_res);
    int unsigned gap;
    logic got;
    deframe_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    serial_bit <= b;
    do @(posedge clk); while (in_stall);
    advance_deframer(b, got, r);
    bits_sent++;
    if (use_typed) begin
      pending_results.push_back(typed_res);
    end else if (got) begin
      pending_results.push_back(r);
    end
  endtask

  // Send a field MSB first; a typed result belongs to its last bit
  task automatic send_field(input logic [49:0] value, input int unsigned nbits,
                            input logic use_typed, input deframe_result_t typed_res);
    for (int i = nbits - 1; i >= 0; i--) begin
      send_bit(value[i], use_typed && (i == 0), typed_res);
    end
  endtask

  // Write the sync register once the block has drained
  task automatic write_sync(input logic [49:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (OUT_LATENCY) @(posedge clk);
    sync_pattern_wr <= 1'b1;
    sync_pattern <= value;
    @(posedge clk);
    sync_pattern_wr <= 1'b0;
    sync_word = value;
  endtask

  task automatic report_mismatch(input string what, input deframe_result_t want,
                                 input deframe_result_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: expected kind=%0d hdr=%h word=%h idx=%0d last=%0d",
               $realtime, what, want.kind, want.header, want.word, want.index, want.last);
      $display("[%0t] %s: actual   kind=%0d hdr=%h word=%h idx=%0d last=%0d",
               $realtime, what, seen.kind, seen.header, seen.word, seen.index, seen.last);
    end
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    deframe_result_t want;
    deframe_result_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen = '{sshd_pkg::event_kind_t'(event_kind), packet_header, payload_word,
               word_index, last_word};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen.kind !== want.kind || seen.header !== want.header ||
            seen.word !== want.word || seen.index !== want.index ||
            seen.last !== want.last) begin
          report_mismatch("result mismatch", want, seen);
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off once the random part starts
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    int unsigned roll;
    bit pressure_done;
    pressure_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (pressure_go && !pressure_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        pressure_done = 1'b1;
      end
      run_len = $urandom_range(1, 30);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 40) stall_len = 0;
      else if (roll < 85) stall_len = $urandom_range(1, 3);
      else if (roll < 97) stall_len = $urandom_range(5, 20);
      else stall_len = $urandom_range(40, 120);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Sender: reset, directed rows, then random packets
  initial begin
    stim_row_t row;
    logic [63:0] raw;
    logic [49:0] hdr;
    logic [7:0] len;
    int unsigned packets;
    int unsigned roll;

    sync_word = '0;
    link_locked = 1'b0;
    hdr_shift = '0;
    hdr_left = '0;
    pay_len = '0;
    word_acc = '0;
    word_fill = '0;
    word_count = '0;

    directed_rows = '{
      // all-ones pattern cannot match a run of zeros
      '{ROW_CFG_WRITE, 6'd0,  ALL_ONES,          1'b0, '0},
      '{ROW_BITS,      6'd3,  50'h0,             1'b0, '0},
      // early match: leading zeros of the pattern are already in the hunt register
      '{ROW_CFG_WRITE, 6'd0,  EARLY_SYNC,        1'b0, '0},
      '{ROW_BITS,      6'd10, EARLY_SYNC,        1'b1,
        '{sshd_pkg::EVT_SYNC, EARLY_SYNC, 10'h0, 8'h0, 1'b0}},
      // pattern is ignored once locked
      '{ROW_CFG_WRITE, 6'd0,  50'h0,             1'b0, '0},
      // zero-length header, everything else set
      '{ROW_BITS,      6'd50, 50'h3FFC03FFFFFFF, 1'b0, '0},
      '{ROW_BITS,      6'd50, 50'h40000000,      1'b0, '0},
      '{ROW_BITS,      6'd10, 50'h3FF,           1'b1,
        '{sshd_pkg::EVT_WORD, 50'h40000000, 10'h3FF, 8'h0, 1'b1}},
      '{ROW_BITS,      6'd50, 50'h2000080000001, 1'b0, '0},
      '{ROW_BITS,      6'd10, 50'h0,             1'b1,
        '{sshd_pkg::EVT_WORD, 50'h2000080000001, 10'h0, 8'h0, 1'b0}},
      '{ROW_BITS,      6'd10, 50'h155,           1'b1,
        '{sshd_pkg::EVT_WORD, 50'h2000080000001, 10'h155, 8'h1, 1'b1}},
      '{ROW_CFG_WRITE, 6'd0,  ALL_ONES,          1'b0, '0},
      '{ROW_BITS,      6'd50, 50'h0,             1'b0, '0},
      '{ROW_BITS,      6'd50, 50'hC0001234,      1'b0, '0},
      '{ROW_BITS,      6'd30, 50'h2AA00600,      1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.op == ROW_CFG_WRITE) write_sync(row.value);
      else send_field(row.value, row.nbits, row.typed, row.res);
    end

    // Random packets with random content and mostly short payloads
    pressure_go = 1'b1;
    packets = 0;
    while (bits_sent < 800) begin
      steady = ($urandom_range(0, 3) == 0);
      if (packets % 6 == 5) begin
        roll = $urandom_range(0, 2);
        raw = {$urandom(), $urandom()};
        if (roll == 0) write_sync(ALL_ONES);
        else if (roll == 1) write_sync(50'h0);
        else write_sync(raw[49:0]);
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) len = 8'd0;
      else if (roll < 80) len = 8'($urandom_range(1, 4));
      else len = 8'($urandom_range(5, 20));
      raw = {$urandom(), $urandom()};
      hdr = raw[49:0];
      hdr[sshd_pkg::LEN_LSB +: sshd_pkg::LEN_W] = len;
      send_field(hdr, sshd_pkg::HDR_W, 1'b0, '0);
      for (int w = 0; w < len; w++) begin
        raw = {$urandom(), $urandom()};
        send_field({40'h0, raw[9:0]}, sshd_pkg::WORD_W, 1'b0, '0);
      end
      packets++;
    end
    steady = 1'b0;

    // Drain, then wait for any stray result
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8 * OUT_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
